// ----- src/assert_macros.svh -----
// Assertion macros for checker files.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
// Implication checked on every clock, off during reset.
`define CHK_IMPL(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);
// Next-cycle implication.
`define CHK_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);
`endif

// ----- src/vet_pkg.sv -----
package vet_pkg;
    localparam int TABLE_DEPTH = 32;
    localparam int IDX_W = $clog2(TABLE_DEPTH);
    localparam int CNT_W = 6;

    localparam logic       OP_MARK  = 1'b0;
    localparam logic       OP_SWEEP = 1'b1;

    localparam logic [2:0] KIND_DONE     = 3'd0;
    localparam logic [2:0] KIND_FULL     = 3'd1;
    localparam logic [2:0] KIND_CHANGES  = 3'd2;
    localparam logic [2:0] KIND_REMOVE   = 3'd3;
    localparam logic [2:0] KIND_INSERTED = 3'd4;
    localparam logic [2:0] KIND_UPDATED  = 3'd5;
    localparam logic [2:0] KIND_DROPPED  = 3'd6;

    // controller -> datapath
    typedef struct packed {
        logic load;       // latch the item fields, clear index
        logic rd;         // read entry at index
        logic step_mark;  // evaluate a read entry for a mark
        logic step_sweep; // evaluate a read entry for a sweep
        logic shift;      // move entry idx-1 into idx (insert)
        logic finish_mark;
        logic finish_sweep;
    } vet_cmd_t;

    // datapath -> controller
    typedef struct packed {
        logic is_sweep;
        logic walk_end;   // index reached count
        logic found;      // mark: position settled
        logic at_pos;     // shift reached insert position
    } vet_sts_t;
endpackage

// ----- src/vet_datapath.sv -----
module vet_datapath
(
    input  logic              clk,
    input  logic              rst_n,
    input  vet_pkg::vet_cmd_t cmd,
    output vet_pkg::vet_sts_t sts,
    input  logic              operation,
    input  logic [15:0]       entity_id,
    input  logic [7:0]        frame,
    input  logic              sweep_reset,
    output logic [15:0]       result_id,
    output logic [2:0]        result_kind,
    output logic [5:0]        entry_count,
    output logic              last,
    output logic              strobe
);
    import vet_pkg::*;

    logic [31:0] mem_q [TABLE_DEPTH];     // {id, first, last}
    logic [31:0] rd_q;

    logic              op_reg;
    logic [15:0]       id_reg;
    logic [7:0]        frame_reg;
    logic              kind_reg;
    logic [CNT_W-1:0]  count_reg, count_next;
    logic [CNT_W-1:0]  idx_reg, idx_next;   // read/shift index
    logic [CNT_W-1:0]  kept_reg, kept_next;
    logic [CNT_W-1:0]  pos_reg, pos_next;
    logic              hit_reg, hit_next, found_next;
    logic [15:0]       rid_reg, rid_next;
    logic [2:0]        rkind_reg, rkind_next;
    logic [5:0]        rcnt_reg, rcnt_next;
    logic              rlast_reg, rlast_next, rstb_reg, rstb_next;

    logic              mwe;
    logic [IDX_W-1:0]  maddr;
    logic [31:0]       mdata;

    logic [15:0] e_id;
    logic [7:0]  e_fs, e_ls, nxt, prv, fs_aged;
    logic [2:0]  skind;
    logic        stays;

    assign e_id = rd_q[31:16];
    assign e_fs = rd_q[15:8];
    assign e_ls = rd_q[7:0];
    assign nxt  = frame_reg + 8'd1;
    assign prv  = frame_reg - 8'd1;
    assign fs_aged = (e_fs == nxt) ? e_fs + 8'd1 : e_fs;
    assign stays = (e_ls != nxt);

    always_comb
    begin
        skind = KIND_DONE;
        if (e_ls == frame_reg)
            skind = (kind_reg || e_fs == frame_reg) ? KIND_FULL : KIND_CHANGES;
        else if (!kind_reg && e_ls == prv)
            skind = KIND_REMOVE;
    end

    always_comb
    begin
        count_next = count_reg;
        idx_next   = idx_reg;
        kept_next  = kept_reg;
        pos_next   = pos_reg;
        hit_next   = hit_reg;
        found_next = 1'b0;
        rid_next   = rid_reg;
        rkind_next = rkind_reg;
        rcnt_next  = rcnt_reg;
        rlast_next = 1'b0;
        rstb_next  = 1'b0;
        mwe   = 1'b0;
        maddr = idx_reg[IDX_W-1:0];
        mdata = 32'd0;
        if (cmd.load)
        begin
            idx_next = '0;
            kept_next = '0;
            hit_next = 1'b0;
        end
        if (cmd.rd)
            idx_next = idx_reg + 1'b1;
        if (cmd.step_mark)
        begin
            // entry idx_reg-1 was read
            if (e_id >= id_reg)
            begin
                found_next = 1'b1;
                pos_next = idx_reg - 1'b1;
                hit_next = (e_id == id_reg);
                // shift starts at the top; nothing moves on a hit or a full table
                if (e_id == id_reg || count_reg >= CNT_W'(TABLE_DEPTH))
                    idx_next = pos_next;
                else
                    idx_next = count_reg;
                if (e_id == id_reg)
                begin
                    mwe = 1'b1;
                    maddr = pos_next[IDX_W-1:0];
                    mdata = {e_id, (e_ls + 8'd1 != frame_reg) ? frame_reg : e_fs, frame_reg};
                end
            end
        end
        if (cmd.step_sweep)
        begin
            if (stays)
            begin
                mwe = 1'b1;
                maddr = kept_reg[IDX_W-1:0];
                mdata = {e_id, fs_aged, e_ls};
                kept_next = kept_reg + 1'b1;
            end
            if (skind != KIND_DONE)
            begin
                rstb_next = 1'b1;
                rid_next = e_id;
                rkind_next = skind;
                rcnt_next = (stays ? kept_reg + 1'b1 : kept_reg) + (count_reg - idx_reg);
            end
        end
        if (cmd.shift)
        begin
            // rd_q holds entry idx_reg-1; write it to idx_reg
            mwe = 1'b1;
            maddr = idx_reg[IDX_W-1:0];
            mdata = rd_q;
            idx_next = idx_reg - 1'b1;
        end
        if (cmd.finish_mark)
        begin
            rstb_next = 1'b1;
            rlast_next = 1'b1;
            rid_next = id_reg;
            if (hit_reg)
                rkind_next = KIND_UPDATED;
            else if (count_reg >= CNT_W'(TABLE_DEPTH))
                rkind_next = KIND_DROPPED;
            else
            begin
                rkind_next = KIND_INSERTED;
                mwe = 1'b1;
                maddr = pos_reg[IDX_W-1:0];
                mdata = {id_reg, frame_reg, frame_reg};
                count_next = count_reg + 1'b1;
            end
            rcnt_next = hit_reg || count_reg >= CNT_W'(TABLE_DEPTH)
                        ? count_reg : count_reg + 1'b1;
        end
        if (cmd.finish_sweep)
        begin
            rstb_next = 1'b1;
            rlast_next = 1'b1;
            rid_next = 16'd0;
            rkind_next = KIND_DONE;
            rcnt_next = kept_reg;
            count_next = kept_reg;
        end
    end

    // read address: walk uses idx_reg, shift reads idx_reg-1
    logic [IDX_W-1:0] raddr;
    assign raddr = (idx_reg == '0) ? '0 : IDX_W'(idx_reg - 1'b1);

    always_ff @(posedge clk)
    begin
        if (mwe)
            mem_q[maddr] <= mdata;
        rd_q <= mem_q[cmd.rd ? idx_reg[IDX_W-1:0] : raddr];
        if (cmd.load)
        begin
            op_reg <= operation;
            id_reg <= entity_id;
            frame_reg <= frame;
            kind_reg <= sweep_reset;
        end
        rid_reg <= rid_next;
        rkind_reg <= rkind_next;
        rcnt_reg <= rcnt_next;
        rlast_reg <= rlast_next;
        pos_reg <= cmd.load ? count_reg : pos_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg <= '0;
            idx_reg <= '0;
            kept_reg <= '0;
            hit_reg <= 1'b0;
            rstb_reg <= 1'b0;
        end
        else
        begin
            count_reg <= count_next;
            idx_reg <= idx_next;
            kept_reg <= kept_next;
            hit_reg <= hit_next;
            rstb_reg <= rstb_next;
        end
    end

    assign sts.is_sweep = op_reg;
    assign sts.walk_end = (idx_reg == count_reg);
    assign sts.found    = found_next;
    assign sts.at_pos   = (idx_reg == pos_reg);

    assign result_id = rid_reg;
    assign result_kind = rkind_reg;
    assign entry_count = rcnt_reg;
    assign last = rlast_reg;
    assign strobe = rstb_reg;
endmodule

// ----- src/vet_ctrl.sv -----
module vet_ctrl
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              start,
    output logic              busy,
    output vet_pkg::vet_cmd_t cmd,
    input  vet_pkg::vet_sts_t sts,
    output logic              shift_go,
    input  logic              shift_done
);
    import vet_pkg::*;

    typedef enum logic [2:0] {
        ST_IDLE, ST_DISPATCH, ST_READ, ST_EVAL, ST_SHIFT_RD, ST_SHIFT_WR,
        ST_FINISH, ST_DRAIN
    } state_t;

    state_t state_reg, state_next;

    always_comb
    begin
        state_next = state_reg;
        cmd = '0;
        shift_go = 1'b0;
        case (state_reg)
            ST_IDLE:
            begin
                if (start)
                begin
                    cmd.load = 1'b1;
                    state_next = ST_DISPATCH;
                end
            end
            ST_DISPATCH, ST_READ:
            begin
                if (sts.walk_end)
                    state_next = sts.is_sweep ? ST_FINISH : ST_SHIFT_RD;
                else
                begin
                    cmd.rd = 1'b1;
                    state_next = ST_EVAL;
                end
            end
            ST_EVAL:
            begin
                if (sts.is_sweep)
                begin
                    cmd.step_sweep = 1'b1;
                    state_next = ST_READ;
                end
                else
                begin
                    cmd.step_mark = 1'b1;
                    state_next = sts.found ? ST_SHIFT_RD : ST_READ;
                end
            end
            ST_SHIFT_RD:
            begin
                // start the shifter; it answers at once when the slot is open
                shift_go = 1'b1;
                state_next = shift_done ? ST_FINISH : ST_SHIFT_WR;
            end
            ST_SHIFT_WR:
            begin
                if (shift_done)
                    state_next = ST_FINISH;
            end
            ST_FINISH:
            begin
                if (sts.is_sweep)
                    cmd.finish_sweep = 1'b1;
                else
                    cmd.finish_mark = 1'b1;
                state_next = ST_DRAIN;
            end
            ST_DRAIN:
                state_next = ST_IDLE;
            default:
                state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            state_reg <= ST_IDLE;
        else
            state_reg <= state_next;
    end

    assign busy = (state_reg != ST_IDLE);
endmodule

// ----- src/vet_shift.sv -----
// Insert shifter: moves entries up one place, top down, to open the slot.
module vet_shift
(
    input  logic clk,
    input  logic rst_n,
    input  logic go,
    input  logic at_pos,
    output logic shift,
    output logic done
);
    typedef enum logic [1:0] {SH_IDLE, SH_READ, SH_WRITE} sh_state_t;
    sh_state_t state_reg, state_next;

    always_comb
    begin
        state_next = state_reg;
        shift = 1'b0;
        done = 1'b0;
        case (state_reg)
            SH_IDLE:
                if (go)
                    state_next = at_pos ? SH_IDLE : SH_READ;
            SH_READ:
                state_next = SH_WRITE;
            SH_WRITE:
            begin
                shift = 1'b1;
                state_next = SH_READ;
            end
            default:
                state_next = SH_IDLE;
        endcase
        if (state_reg == SH_READ && at_pos)
        begin
            state_next = SH_IDLE;
            done = 1'b1;
        end
        if (state_reg == SH_IDLE && go && at_pos)
            done = 1'b1;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            state_reg <= SH_IDLE;
        else
            state_reg <= state_next;
    end
endmodule

// ----- src/visible_entity_table.sv -----
// Visible entity table. Start an item with start while busy is low; results
// come on strobe, one cycle each, and cannot be stalled. A mark walks the
// table from the low end until it meets an id not below its own (a read
// state, then an evaluate state, per entry); for an insert the shifter then
// moves the entries above the slot up one place (a read, then a write, each),
// then the mark reports. A sweep reads and evaluates each entry in turn
// through the single table memory and ends with done. The final result
// shows in the cycle before busy falls.
module visible_entity_table
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        start,
    output logic        busy,
    input  logic        operation,
    input  logic [15:0] entity_id,
    input  logic [7:0]  frame,
    input  logic        sweep_reset,
    output logic        strobe,
    output logic [15:0] result_id,
    output logic [2:0]  result_kind,
    output logic [5:0]  entry_count,
    output logic        last
);
    import vet_pkg::*;

    vet_cmd_t ccmd, dcmd;
    vet_sts_t sts;
    logic     sh_go, sh_shift, sh_done;

    vet_ctrl u_ctrl
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .start      (start),
        .busy       (busy),
        .cmd        (ccmd),
        .sts        (sts),
        .shift_go   (sh_go),
        .shift_done (sh_done)
    );

    // Mark path: the controller starts the shifter and waits for its done;
    // the shifter steps the datapath until the insert slot is open.
    vet_shift u_shift
    (
        .clk    (clk),
        .rst_n  (rst_n),
        .go     (sh_go),
        .at_pos (sts.at_pos),
        .shift  (sh_shift),
        .done   (sh_done)
    );

    always_comb
    begin
        dcmd = ccmd;
        dcmd.shift = sh_shift;
    end

    vet_datapath u_dp
    (
        .clk         (clk),
        .rst_n       (rst_n),
        .cmd         (dcmd),
        .sts         (sts),
        .operation   (operation),
        .entity_id   (entity_id),
        .frame       (frame),
        .sweep_reset (sweep_reset),
        .result_id   (result_id),
        .result_kind (result_kind),
        .entry_count (entry_count),
        .last        (last),
        .strobe      (strobe)
    );
endmodule

// ----- src/vet_checker.sv -----
`include "assert_macros.svh"
module vet_checker
(
    input logic       clk,
    input logic       rst_n,
    input logic       start,
    input logic       busy,
    input logic       strobe,
    input logic       last,
    input logic [2:0] result_kind,
    input logic [5:0] entry_count
);
    import vet_pkg::*;

    `CHK_NEXT(a_busy_after_start, clk, rst_n, start && !busy, busy, "start not taken")
    `CHK_IMPL(a_count_range, clk, rst_n, strobe, entry_count <= 6'(TABLE_DEPTH), "count too big")
    `CHK_IMPL(a_done_last, clk, rst_n, strobe && result_kind == KIND_DONE, last, "done not last")
    `CHK_IMPL(a_kind_range, clk, rst_n, strobe, result_kind <= KIND_DROPPED, "bad kind")
endmodule

bind visible_entity_table vet_checker u_chk
(
    .clk (clk), .rst_n (rst_n), .start (start), .busy (busy), .strobe (strobe),
    .last (last), .result_kind (result_kind), .entry_count (entry_count)
);
